[hw/rtl/scg_pkg.sv]
// Shared types and constants of the strided convolution / GELU core.
// No dependencies; scg_if, scg_erf_rom, scg_mac and the top level use it.
package scg_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD_W  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_LOAD_P  = 2'd2,
        KIND_COMPUTE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_GEOM  = 2'd2
    } t_err;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 7;

    typedef enum logic [CFG_IW-1:0] {
        CFG_IN_CH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_WIDTH  = 3'd2,
        CFG_OUT_CH = 3'd3,
        CFG_KERNEL = 3'd4,
        CFG_PAD    = 3'd5
    } t_cfg_idx;

    localparam logic [5:0] RST_IN_CH  = 6'd3;
    localparam logic [6:0] RST_HEIGHT = 7'd64;
    localparam logic [6:0] RST_WIDTH  = 7'd64;
    localparam logic [6:0] RST_OUT_CH = 7'd32;
    localparam logic [2:0] RST_KERNEL = 3'd5;
    localparam logic [1:0] RST_PAD    = 2'd2;

    // erf table generation
    localparam logic [63:0] FINE_STEPS  = 64'd2048;
    localparam logic [63:0] GAUSS_Q     = 64'd4294934528;
    localparam logic [63:0] SQRT2_PI_Q31 = 64'd1713444047;
    localparam logic [16:0] ERF_ONE     = 17'd65536;

    localparam int ACC_W = 40;
    localparam int MUL_W = 19;
    localparam int PRD_W = 2 * MUL_W;

    typedef struct packed {
        logic acc_init;
        logic acc_add;
    } t_mac_ctl;

endpackage

[hw/rtl/scg_if.sv]
// Handshake channels of the core: input items, result items, register writes.
// Depends on scg_pkg for the register port widths.
interface scg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [14:0] load_index;
    logic signed [15:0] load_value;
    logic [5:0]  query_channel;
    logic [5:0]  query_row;
    logic [5:0]  query_col;
    modport source (output valid, kind, load_index, load_value, query_channel,
                    query_row, query_col, input ready);
    modport sink (input valid, kind, load_index, load_value, query_channel,
                  query_row, query_col, output ready);
endinterface

interface scg_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] result_value;
    logic [1:0]  error_code;
    modport source (output valid, result_value, error_code, input ready);
    modport sink (input valid, result_value, error_code, output ready);
endinterface

interface scg_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [scg_pkg::CFG_IW-1:0]  index;
    logic [scg_pkg::CFG_DW-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/scg_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module scg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/scg_erf_rom.sv]
// erf(t/sqrt2) table in unsigned Q1.16, built at elaboration, registered read.
// Depends on scg_pkg for the generation constants.
module scg_erf_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic [$clog2(DEPTH)-1:0]     i_addr,
    output logic [16:0]                  o_data
);
    import scg_pkg::*;

    typedef logic [16:0] t_rom [DEPTH];

    function automatic t_rom build_table();
        t_rom        tab;
        logic [63:0] g, r, q2, s, cur, target, gn, v, e;
        g   = 64'h1_0000_0000;
        r   = GAUSS_Q;
        q2  = (GAUSS_Q * GAUSS_Q) >> 32;
        s   = '0;
        cur = '0;
        for (int i = 0; i < DEPTH; i++) begin
            target = (64'(i) * FINE_STEPS) / 64'(DEPTH);
            while (cur < target) begin
                gn  = (g * r) >> 32;
                s   = s + g + gn;
                g   = gn;
                r   = (r * q2) >> 32;
                cur = cur + 64'd1;
            end
            v = ((s >> 9) * SQRT2_PI_Q31) >> 31;
            e = (v + 64'd32768) >> 16;
            if (e > 64'(ERF_ONE)) begin
                e = 64'(ERF_ONE);
            end
            tab[i] = e[16:0];
        end
        return tab;
    endfunction

    localparam t_rom ROM = build_table();

    logic [16:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM[i_addr];
    end

    assign o_data = r_data;
endmodule

[hw/rtl/scg_mac.sv]
// Shared signed multiplier with a saturating 40-bit accumulator.
// Depends on scg_pkg for widths and the control struct.
module scg_mac (
    input  logic                          i_clk,
    input  scg_pkg::t_mac_ctl             i_ctl,
    input  logic signed [scg_pkg::MUL_W-1:0] i_a,
    input  logic signed [scg_pkg::MUL_W-1:0] i_b,
    input  logic signed [15:0]            i_bias,
    output logic signed [scg_pkg::PRD_W-1:0] o_prod,
    output logic signed [scg_pkg::ACC_W-1:0] o_acc
);
    import scg_pkg::*;

    logic signed [PRD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W:0]   sum;

    assign sum = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(r_prod);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.acc_init) begin
            n_acc = {{(ACC_W-28){i_bias[15]}}, i_bias, 12'd0};
        end else if (i_ctl.acc_add) begin
            if (sum[ACC_W] != sum[ACC_W-1]) begin
                // clamp on overflow
                n_acc = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                n_acc = sum[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_acc  <= n_acc;
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;
endmodule

[hw/rtl/strided_conv_gelu_core.sv]
// Top level: sequencer, configuration registers, stores and result register.
// Depends on scg_pkg, scg_if, scg_ram, scg_erf_rom and scg_mac.
//
//  channel  dir  handshake        payload
//  i_in     in   valid/ready      kind, load_index, load_value, query_*
//  o_res    out  valid/ready      result_value, error_code
//  i_cfg    in   valid/ready      index, data (ready always high)
//
// A load item within the store's depth is written when it is accepted. After a compute
// item is accepted the block is not ready until its result has gone to the output
// register. Good geometry and query walk in_channels*kernel^2 terms (one multiply-
// accumulate a cycle through the shared multiplier and the store read ports); else an
// error result follows the checks. Loads go on while a result waits in the output register.
// Reset clears control and configuration, not the stores.
module strided_conv_gelu_core #(
    parameter int MAX_WEIGHTS      = 32768,
    parameter int MAX_PIXELS       = 16384,
    parameter int MAX_OUT_CHANNELS = 64,
    parameter int GELU_TABLE_DEPTH = 1024
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    scg_in_if.sink   i_in,
    scg_out_if.source o_res,
    scg_cfg_if.sink  i_cfg
);
    import scg_pkg::*;

    localparam int WAW = MAX_WEIGHTS > 1 ? $clog2(MAX_WEIGHTS) : 1;
    localparam int PAW = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
    localparam int BAW = MAX_OUT_CHANNELS > 1 ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int TAW = $clog2(GELU_TABLE_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_GEO1  = 10'b0000000010,
        S_GEO2  = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_BIAS  = 10'b0000010000,
        S_RUN   = 10'b0000100000,
        S_DRAIN = 10'b0001000000,
        S_ROUND = 10'b0010000000,
        S_TABLE = 10'b0100000000,
        S_GMUL  = 10'b1000000000
    } t_state;

    // the result leaves through S_IDLE after S_GMUL finishes; S_FIN is folded in
    t_state r_state, n_state;
    logic   r_fin;
    logic   r_gmul_d;

    // configuration
    logic [5:0] r_c;
    logic [6:0] r_h, r_w, r_oc;
    logic [2:0] r_k;
    logic [1:0] r_p;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c  <= RST_IN_CH;
            r_h  <= RST_HEIGHT;
            r_w  <= RST_WIDTH;
            r_oc <= RST_OUT_CH;
            r_k  <= RST_KERNEL;
            r_p  <= RST_PAD;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IN_CH:  r_c  <= i_cfg.data[5:0];
                CFG_HEIGHT: r_h  <= i_cfg.data;
                CFG_WIDTH:  r_w  <= i_cfg.data;
                CFG_OUT_CH: r_oc <= i_cfg.data;
                CFG_KERNEL: r_k  <= i_cfg.data[2:0];
                CFG_PAD:    r_p  <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // loads
    logic        in_acc;
    logic [20:0] idx21;
    logic        we_w, we_b, we_p;

    assign i_in.ready = (r_state == S_IDLE) && !r_fin && !r_gmul_d;
    assign in_acc = i_in.valid && i_in.ready;
    assign idx21  = 21'(i_in.load_index);
    assign we_w = in_acc && (i_in.kind == KIND_LOAD_W) && (32'(idx21) < MAX_WEIGHTS);
    assign we_b = in_acc && (i_in.kind == KIND_LOAD_B) && (32'(idx21) < MAX_OUT_CHANNELS);
    assign we_p = in_acc && (i_in.kind == KIND_LOAD_P) && (32'(idx21) < MAX_PIXELS);

    // query and geometry
    logic [5:0]  r_qc, r_qr, r_qx;
    logic [12:0] r_ch, r_oci;
    logic [5:0]  r_kk;
    logic [13:0] r_hw;
    logic signed [8:0]  r_iy0, r_ix0;
    logic signed [17:0] r_roff0;
    logic [19:0] r_pixcnt;
    logic [18:0] r_wcnt;
    logic [11:0] r_ckk;
    logic [WAW-1:0] r_wbase;

    logic signed [8:0] iy0, ix0;
    assign iy0 = $signed({2'b00, r_qr, 1'b0}) - $signed({7'd0, r_p});
    assign ix0 = $signed({2'b00, r_qx, 1'b0}) - $signed({7'd0, r_p});

    logic [7:0] hp, wp, oh, ow;
    logic       geo_bad, range_bad;
    assign hp = 8'(r_h) + 8'({r_p, 1'b0});
    assign wp = 8'(r_w) + 8'({r_p, 1'b0});
    assign oh = ((hp - 8'(r_k)) >> 1) + 8'd1;
    assign ow = ((wp - 8'(r_k)) >> 1) + 8'd1;
    assign geo_bad = (r_c == 6'd0) || (r_h == 7'd0) || (r_w == 7'd0) || (r_oc == 7'd0)
                  || (r_k == 3'd0) || (hp < 8'(r_k)) || (wp < 8'(r_k))
                  || (32'(r_oc) > MAX_OUT_CHANNELS) || (32'(r_pixcnt) > MAX_PIXELS)
                  || (32'(r_wcnt) > MAX_WEIGHTS);
    assign range_bad = (7'(r_qc) >= r_oc) || (8'(r_qr) >= oh) || (8'(r_qx) >= ow);

    // walk counters
    logic [5:0]  r_ic;
    logic [2:0]  r_ky, r_kx;
    logic [WAW-1:0] r_waddr;
    logic [20:0] r_cbase;
    logic signed [17:0] r_roff;
    logic signed [8:0]  r_iy, r_ix;
    logic        in_map, last_term;
    logic signed [21:0] paddr;

    assign in_map = !r_iy[8] && !r_ix[8] && (r_iy < $signed({2'b00, r_h}))
                 && (r_ix < $signed({2'b00, r_w}));
    assign paddr  = $signed({1'b0, r_cbase}) + 22'(r_roff) + 22'(r_ix);
    assign last_term = (r_ic == r_c - 6'd1) && (r_ky == r_k - 3'd1) && (r_kx == r_k - 3'd1);

    // stores
    logic [15:0] w_rdata, b_rdata, p_rdata;
    logic [16:0] erf_data;
    logic [TAW-1:0] tab_addr;
    logic [10:0] qc11;
    assign qc11 = 11'(r_qc);

    scg_ram #(.WIDTH(16), .DEPTH(MAX_WEIGHTS)) u_wram (
        .i_clk(i_clk), .i_we(we_w), .i_waddr(idx21[WAW-1:0]),
        .i_wdata(i_in.load_value), .i_raddr(r_waddr), .o_rdata(w_rdata));
    scg_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CHANNELS)) u_bram (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(idx21[BAW-1:0]),
        .i_wdata(i_in.load_value), .i_raddr(qc11[BAW-1:0]), .o_rdata(b_rdata));
    scg_ram #(.WIDTH(16), .DEPTH(MAX_PIXELS)) u_pram (
        .i_clk(i_clk), .i_we(we_p), .i_waddr(idx21[PAW-1:0]),
        .i_wdata(i_in.load_value), .i_raddr(paddr[PAW-1:0]), .o_rdata(p_rdata));
    scg_erf_rom #(.DEPTH(GELU_TABLE_DEPTH)) u_rom (
        .i_clk(i_clk), .i_addr(tab_addr), .o_data(erf_data));

    // shared multiplier
    logic r_v1, r_v2, r_in1;
    t_mac_ctl ctl;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] prod;
    logic signed [ACC_W-1:0] acc;
    logic signed [15:0] r_x;
    logic signed [MUL_W-1:0] f;

    assign f = r_x[15] ? $signed(19'(ERF_ONE) - 19'(erf_data))
                       : $signed(19'(ERF_ONE) + 19'(erf_data));

    always_comb begin
        if (r_state == S_GMUL) begin
            mul_a = MUL_W'(r_x);
            mul_b = f;
        end else begin
            mul_a = MUL_W'($signed(w_rdata));
            mul_b = r_in1 ? MUL_W'($signed(p_rdata)) : '0;
        end
        ctl.acc_init = (r_state == S_BIAS);
        ctl.acc_add  = r_v2;
    end

    scg_mac u_mac (
        .i_clk(i_clk), .i_ctl(ctl), .i_a(mul_a), .i_b(mul_b),
        .i_bias($signed(b_rdata)), .o_prod(prod), .o_acc(acc));

    // rounding to Q4.12 and table index
    logic signed [ACC_W:0] acc_r;
    logic signed [28:0]    acc_q;
    logic signed [15:0]    x_sat;
    logic [15:0]  ax;
    logic [32:0]  idx_full;
    assign acc_r = {acc[ACC_W-1], acc} + 41'sd2048;
    assign acc_q = 29'(acc_r >>> 12);
    assign x_sat = (acc_q > 29'sd32767) ? 16'sh7fff
                 : (acc_q < -29'sd32768) ? 16'sh8000 : acc_q[15:0];
    assign ax = r_x[15] ? 16'(-r_x) : r_x;
    assign idx_full = (33'(ax) * 33'(GELU_TABLE_DEPTH)) >> 15;
    assign tab_addr = (idx_full >= 33'(GELU_TABLE_DEPTH)) ? TAW'(GELU_TABLE_DEPTH - 1)
                                                         : idx_full[TAW-1:0];

    // GELU final scaling
    logic signed [PRD_W-1:0] g_sum;
    logic signed [20:0]      g_q;
    logic signed [15:0]      g_sat;
    assign g_sum = prod + PRD_W'(65536);
    assign g_q   = 21'(g_sum >>> 17);
    assign g_sat = (g_q > 21'sd32767) ? 16'sh7fff
                 : (g_q < -21'sd32768) ? 16'sh8000 : g_q[15:0];

    // result holding
    logic signed [15:0] r_res_val;
    logic [1:0]         r_res_err;
    logic               r_out_valid;
    logic signed [15:0] r_out_val;
    logic [1:0]         r_out_err;
    logic               gmul_done;

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_val;
    assign o_res.error_code   = r_out_err;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && i_in.kind == KIND_COMPUTE) n_state = S_GEO1;
            S_GEO1:  n_state = S_GEO2;
            S_GEO2:  n_state = S_CHECK;
            S_CHECK: n_state = (geo_bad || range_bad) ? S_IDLE : S_BIAS;
            S_BIAS:  n_state = S_RUN;
            S_RUN:   if (last_term) n_state = S_DRAIN;
            S_DRAIN: if (!r_v1 && !r_v2) n_state = S_ROUND;
            S_ROUND: n_state = S_TABLE;
            S_TABLE: n_state = S_GMUL;
            S_GMUL:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // r_fin marks a finished result that still waits for the output register
    assign gmul_done = (r_state == S_GMUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_RUN);
            r_v2    <= r_v1;
            if (r_state == S_CHECK && (geo_bad || range_bad)) begin
                r_fin <= 1'b1;
            end else if (r_gmul_d) begin
                r_fin <= 1'b1;
            end else if (r_fin && (!r_out_valid || o_res.ready)) begin
                r_fin <= 1'b0;
            end
            if (r_fin && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in1 <= in_map;
        if (r_fin && (!r_out_valid || o_res.ready)) begin
            r_out_val <= r_res_val;
            r_out_err <= r_res_err;
        end
        if (in_acc) begin
            r_qc <= i_in.query_channel;
            r_qr <= i_in.query_row;
            r_qx <= i_in.query_col;
        end
        unique case (r_state)
            S_GEO1: begin
                r_ch    <= 13'(r_c) * 13'(r_h);
                r_oci   <= 13'(r_oc) * 13'(r_c);
                r_kk    <= 6'(r_k) * 6'(r_k);
                r_hw    <= 14'(r_h) * 14'(r_w);
                r_iy0   <= iy0;
                r_ix0   <= ix0;
                r_roff0 <= 18'(iy0) * $signed({11'd0, r_w});
            end
            S_GEO2: begin
                r_pixcnt <= 20'(r_ch) * 20'(r_w);
                r_wcnt   <= 19'(r_oci) * 19'(r_kk);
                r_ckk    <= 12'(r_c) * 12'(r_kk);
            end
            S_CHECK: begin
                r_wbase <= WAW'(21'(r_qc) * 21'(r_ckk));
                r_res_val <= '0;
                r_res_err <= geo_bad ? ERR_GEOM : (range_bad ? ERR_RANGE : ERR_OK);
            end
            S_BIAS: begin
                r_waddr <= r_wbase;
                r_ic    <= '0;
                r_ky    <= '0;
                r_kx    <= '0;
                r_cbase <= '0;
                r_roff  <= r_roff0;
                r_iy    <= r_iy0;
                r_ix    <= r_ix0;
            end
            S_RUN: begin
                // advance kx, then ky, then channel
                r_waddr <= r_waddr + WAW'(1);
                if (r_kx != r_k - 3'd1) begin
                    r_kx <= r_kx + 3'd1;
                    r_ix <= r_ix + 9'sd1;
                end else begin
                    r_kx <= '0;
                    r_ix <= r_ix0;
                    if (r_ky != r_k - 3'd1) begin
                        r_ky   <= r_ky + 3'd1;
                        r_iy   <= r_iy + 9'sd1;
                        r_roff <= r_roff + $signed({11'd0, r_w});
                    end else begin
                        r_ky    <= '0;
                        r_iy    <= r_iy0;
                        r_roff  <= r_roff0;
                        r_ic    <= r_ic + 6'd1;
                        r_cbase <= r_cbase + 21'(r_hw);
                    end
                end
            end
            S_ROUND: r_x <= x_sat;
            S_GMUL: ;
            default: ;
        endcase
        if (r_gmul_d) begin
            r_res_val <= g_sat;
        end
    end

    // the GELU product lands in the cycle after S_GMUL; r_gmul_d marks that cycle for its capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gmul_d <= 1'b0;
        end else begin
            r_gmul_d <= gmul_done;
        end
    end
endmodule
